// File: rtl/core/rgbm_pkg.sv
// Shared constants and types for the RGB LED matrix scan driver.
package rgbm_pkg;

  // Default panel geometry.
  localparam int unsigned SHIFT_LENGTH_DEF  = 32;
  localparam int unsigned PANEL_COLUMNS_DEF = 16;

  // Field and register widths.
  localparam int unsigned COLOR_W        = 3;
  localparam int unsigned ROW_ADDR_W     = 3;
  localparam int unsigned PIXEL_HOLD_W   = 8;
  localparam int unsigned DISPLAY_HOLD_W = 10;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;

  // Register reset values.
  localparam logic [PIXEL_HOLD_W-1:0]   PIXEL_HOLD_RST   = 8'd2;
  localparam logic [DISPLAY_HOLD_W-1:0] DISPLAY_HOLD_RST = 10'd200;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_PIXEL_HOLD   = 1'b0;
  localparam logic REG_DISPLAY_HOLD = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;

  // Access control from the sequencer to the frame store.
  typedef struct packed {
    logic wr_en;
    logic wr_second;
    logic rd_en;
  } mem_ctrl_t;

endpackage

// File: rtl/core/rgbm_frame_store.sv
// Frame store: two half-panel color memories with a clearing pass after reset.
module rgbm_frame_store #(
  parameter int unsigned SHIFT_LENGTH  = rgbm_pkg::SHIFT_LENGTH_DEF,
  parameter int unsigned PANEL_COLUMNS = rgbm_pkg::PANEL_COLUMNS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  rgbm_pkg::mem_ctrl_t                                  ctrl_i,
  input  logic [$clog2(SHIFT_LENGTH*(PANEL_COLUMNS/2))-1:0]    wr_addr_i,
  input  rgbm_pkg::color_t                                     wr_color_i,
  input  logic [$clog2(SHIFT_LENGTH*(PANEL_COLUMNS/2))-1:0]    rd_addr_i,
  output rgbm_pkg::color_t                                     rd_first_o,
  output rgbm_pkg::color_t                                     rd_second_o,
  output logic                                                 clearing_o
);
  import rgbm_pkg::*;

  localparam int unsigned HALF  = PANEL_COLUMNS / 2;
  localparam int unsigned DEPTH = SHIFT_LENGTH * HALF;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  color_t mem_first_q  [DEPTH];
  color_t mem_second_q [DEPTH];
  color_t rd_first_q;
  color_t rd_second_q;

  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  // Clearing pass: one entry of each half per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CLR_LAST) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Memory write port; the clearing pass has priority.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_first_q[clr_addr_q]  <= '0;
      mem_second_q[clr_addr_q] <= '0;
    end else if (ctrl_i.wr_en) begin
      if (ctrl_i.wr_second) begin
        mem_second_q[wr_addr_i] <= wr_color_i;
      end else begin
        mem_first_q[wr_addr_i] <= wr_color_i;
      end
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_first_q  <= mem_first_q[rd_addr_i];
      rd_second_q <= mem_second_q[rd_addr_i];
    end
  end

  assign rd_first_o  = rd_first_q;
  assign rd_second_o = rd_second_q;
  assign clearing_o  = clearing_q;

endmodule

// File: rtl/core/rgb_led_matrix_scan_driver.sv
// Top level of the RGB LED matrix scan driver: sequencer, registers and output stage.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   command, pixel_row, pixel_col, pixel_color
//   out       output     out_valid_o / out_stall_i panel colors, shift_clock, latch_strobe,
//                                                  output_enable, row_address
//   config    input      APB psel/penable/pwrite   pixel_hold_ticks, display_hold_ticks
//
// An item is taken every clock cycle while in_stall_o is low; a tick item shows its pin
// state in the next cycle, set by the single read port of the frame store and the output register.
// After reset the frame store clears all SHIFT_LENGTH * (PANEL_COLUMNS / 2) entries of each half
// (256 at the default size) while in_stall_o stays high; configuration writes still work.
// A stall on the output holds the result and stalls the input in the same cycle.
module rgb_led_matrix_scan_driver #(
  parameter int unsigned SHIFT_LENGTH  = rgbm_pkg::SHIFT_LENGTH_DEF,
  parameter int unsigned PANEL_COLUMNS = rgbm_pkg::PANEL_COLUMNS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input item channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [$clog2(SHIFT_LENGTH)-1:0]        pixel_row_i,
  input  logic [$clog2(PANEL_COLUMNS)-1:0]       pixel_col_i,
  input  logic [rgbm_pkg::COLOR_W-1:0]           pixel_color_i,
  // Result item channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   red_first_o,
  output logic                                   green_first_o,
  output logic                                   blue_first_o,
  output logic                                   red_second_o,
  output logic                                   green_second_o,
  output logic                                   blue_second_o,
  output logic                                   shift_clock_o,
  output logic                                   latch_strobe_o,
  output logic                                   output_enable_o,
  output logic [rgbm_pkg::ROW_ADDR_W-1:0]        row_address_o,
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rgbm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [rgbm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [rgbm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import rgbm_pkg::*;

  localparam int unsigned HALF   = PANEL_COLUMNS / 2;
  localparam int unsigned DEPTH  = SHIFT_LENGTH * HALF;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned ROW_W  = $clog2(SHIFT_LENGTH);
  localparam int unsigned COL_W  = $clog2(PANEL_COLUMNS);
  localparam int unsigned GRP_W  = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned HOLD_W = DISPLAY_HOLD_W;

  localparam logic [ROW_W-1:0] POS_LAST    = ROW_W'(SHIFT_LENGTH - 1);
  localparam logic [GRP_W-1:0] GRP_LAST    = GRP_W'(HALF - 1);
  localparam logic [ROW_W:0]   ROW_LIMIT   = (ROW_W + 1)'(SHIFT_LENGTH);
  localparam logic [COL_W:0]   COL_LIMIT   = (COL_W + 1)'(2 * HALF);
  localparam logic [COL_W:0]   COL_HALF    = (COL_W + 1)'(HALF);

  // Scan phase codes.
  localparam logic [2:0] PH_SETUP   = 3'd0;
  localparam logic [2:0] PH_HOLD    = 3'd1;
  localparam logic [2:0] PH_CLOCK   = 3'd2;
  localparam logic [2:0] PH_LATCH   = 3'd3;
  localparam logic [2:0] PH_DISPLAY = 3'd4;

  // Configuration registers.
  logic [PIXEL_HOLD_W-1:0]   pixel_hold_q;
  logic [DISPLAY_HOLD_W-1:0] display_hold_q;
  logic                      cfg_write;

  assign cfg_write = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_hold_q   <= PIXEL_HOLD_RST;
      display_hold_q <= DISPLAY_HOLD_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PIXEL_HOLD:   pixel_hold_q   <= pwdata[PIXEL_HOLD_W-1:0];
        REG_DISPLAY_HOLD: display_hold_q <= pwdata[DISPLAY_HOLD_W-1:0];
        default:          pixel_hold_q   <= pixel_hold_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_PIXEL_HOLD:   prdata[PIXEL_HOLD_W-1:0]   = pixel_hold_q;
      REG_DISPLAY_HOLD: prdata[DISPLAY_HOLD_W-1:0] = display_hold_q;
      default:          prdata = '0;
    endcase
  end

  // Input handshake.
  logic clearing;
  logic out_valid_q;
  logic in_accept;
  logic tick_accept;
  logic write_accept;

  assign in_stall_o   = clearing | (out_valid_q & out_stall_i);
  assign in_accept    = in_valid_i & ~in_stall_o;
  assign tick_accept  = in_accept & (command_i == CMD_TICK);
  assign write_accept = in_accept & (command_i == CMD_WRITE);

  // Sequencer state.
  logic [2:0]        phase_q, phase_d;
  logic [GRP_W-1:0]  group_q, group_d;
  logic [ROW_W-1:0]  pos_q, pos_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic              clk_d, lat_d, oe_d, color_en_d;

  logic [HOLD_W:0]   hold_inc;
  logic              pixel_done;
  logic              display_done;
  logic [GRP_W-1:0]  group_next;
  logic [2:0]        shift_entry;

  assign hold_inc     = {1'b0, hold_q} + 1'b1;
  assign pixel_done   = hold_inc >= (HOLD_W + 1)'(pixel_hold_q);
  assign display_done = hold_inc >= (HOLD_W + 1)'(display_hold_q);
  assign group_next   = (group_q == GRP_LAST) ? '0 : group_q + 1'b1;
  assign shift_entry  = (pixel_hold_q != '0) ? PH_HOLD : PH_CLOCK;

  // Next state and pin state of one tick.
  always_comb begin
    phase_d    = phase_q;
    group_d    = group_q;
    pos_d      = pos_q;
    hold_d     = hold_q;
    clk_d      = 1'b0;
    lat_d      = 1'b0;
    oe_d       = 1'b1;
    color_en_d = 1'b0;
    unique case (phase_q)
      PH_HOLD: begin
        color_en_d = 1'b1;
        if (pixel_done) begin
          hold_d  = '0;
          phase_d = PH_CLOCK;
        end else begin
          hold_d = hold_inc[HOLD_W-1:0];
        end
      end
      PH_CLOCK: begin
        color_en_d = 1'b1;
        clk_d      = 1'b1;
        if (pos_q == POS_LAST) begin
          phase_d = PH_LATCH;
        end else begin
          pos_d   = pos_q + 1'b1;
          hold_d  = '0;
          phase_d = shift_entry;
        end
      end
      PH_LATCH: begin
        lat_d = 1'b1;
        if (display_hold_q != '0) begin
          hold_d  = '0;
          phase_d = PH_DISPLAY;
        end else begin
          group_d = group_next;
          pos_d   = '0;
          hold_d  = '0;
          phase_d = PH_SETUP;
        end
      end
      PH_DISPLAY: begin
        oe_d = 1'b0;
        if (display_done) begin
          group_d = group_next;
          pos_d   = '0;
          hold_d  = '0;
          phase_d = PH_SETUP;
        end else begin
          hold_d = hold_inc[HOLD_W-1:0];
        end
      end
      default: begin
        // Setup: blank, show shift position zero, then start shifting.
        color_en_d = 1'b1;
        pos_d      = '0;
        hold_d     = '0;
        phase_d    = shift_entry;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SETUP;
      group_q <= '0;
      pos_q   <= '0;
      hold_q  <= '0;
    end else if (tick_accept) begin
      phase_q <= phase_d;
      group_q <= group_d;
      pos_q   <= pos_d;
      hold_q  <= hold_d;
    end
  end

  // Frame store addressing: row-major within each half of the panel.
  logic              wr_in_range;
  logic              wr_second;
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    col_in_half;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  mem_ctrl_t         mem_ctrl;
  color_t            rd_first;
  color_t            rd_second;

  assign col_ext     = {1'b0, pixel_col_i};
  assign wr_in_range = ({1'b0, pixel_row_i} < ROW_LIMIT) && (col_ext < COL_LIMIT);
  assign wr_second   = col_ext >= COL_HALF;
  assign col_in_half = wr_second ? (col_ext - COL_HALF) : col_ext;
  assign wr_addr     = AW'(pixel_row_i) * AW'(HALF) + AW'(col_in_half);
  assign rd_addr     = AW'(pos_q) * AW'(HALF) + AW'(group_q);

  assign mem_ctrl.wr_en     = write_accept & wr_in_range;
  assign mem_ctrl.wr_second = wr_second;
  assign mem_ctrl.rd_en     = tick_accept;

  rgbm_frame_store #(
    .SHIFT_LENGTH  (SHIFT_LENGTH),
    .PANEL_COLUMNS (PANEL_COLUMNS)
  ) u_frame_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mem_ctrl),
    .wr_addr_i   (wr_addr),
    .wr_color_i  (pixel_color_i),
    .rd_addr_i   (rd_addr),
    .rd_first_o  (rd_first),
    .rd_second_o (rd_second),
    .clearing_o  (clearing)
  );

  // Output register; the row address is the group the tick was taken in.
  logic                  clk_q, lat_q, oe_q, color_en_q;
  logic [ROW_ADDR_W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      clk_q      <= clk_d;
      lat_q      <= lat_d;
      oe_q       <= oe_d;
      color_en_q <= color_en_d;
      row_q      <= ROW_ADDR_W'(group_q);
    end
  end

  // Colors are dark outside the setup and shifting phases.
  color_t first_color;
  color_t second_color;

  assign first_color  = rd_first & {COLOR_W{color_en_q}};
  assign second_color = rd_second & {COLOR_W{color_en_q}};

  assign out_valid_o     = out_valid_q;
  assign red_first_o     = first_color[0];
  assign green_first_o   = first_color[1];
  assign blue_first_o    = first_color[2];
  assign red_second_o    = second_color[0];
  assign green_second_o  = second_color[1];
  assign blue_second_o   = second_color[2];
  assign shift_clock_o   = clk_q;
  assign latch_strobe_o  = lat_q;
  assign output_enable_o = oe_q;
  assign row_address_o   = row_q;

  // No item enters while the frame store is being cleared.
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> in_stall_o
  ) else $error("item accepted during frame store clearing pass");

  // Every accepted tick yields a result in the next cycle.
  a_tick_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) tick_accept |=> out_valid_o
  ) else $error("accepted tick produced no result");

  // A lit group shows no shift activity and dark color lines.
  a_lit_is_quiet : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !output_enable_o) |->
      (!shift_clock_o && !latch_strobe_o && first_color == '0 && second_color == '0)
  ) else $error("activity on panel lines while group is lit");

  // Shift clock and latch never pulse together.
  a_clock_latch_apart : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(shift_clock_o && latch_strobe_o)
  ) else $error("shift clock and latch high in the same tick");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the RGB LED matrix scan driver.
`timescale 1ns / 1ps

module tb_top;
  import rgbm_pkg::*;

  localparam int unsigned ROWS  = SHIFT_LENGTH_DEF;
  localparam int unsigned COLS  = PANEL_COLUMNS_DEF;
  localparam int unsigned HALF  = COLS / 2;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned COL_W = $clog2(COLS);
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  typedef enum logic [2:0] {
    SCAN_SETUP,
    SCAN_HOLD,
    SCAN_CLOCK,
    SCAN_LATCH,
    SCAN_DISPLAY
  } scan_phase_e;

  // One panel pin state; colors are {blue, green, red}.
  typedef struct packed {
    logic [COLOR_W-1:0]    first_rgb;
    logic [COLOR_W-1:0]    second_rgb;
    logic                  shift_clk;
    logic                  latch;
    logic                  blank;
    logic [ROW_ADDR_W-1:0] row_addr;
  } pin_state_t;

  // Predicts the pin state of every tick and checks the ones the block gives.
  class pin_scoreboard;
    logic [COLOR_W-1:0] frame [ROWS][COLS];
    int unsigned group;
    int unsigned pos;
    int unsigned hold_cnt;
    scan_phase_e phase;
    int unsigned pixel_hold;
    int unsigned display_hold;
    pin_state_t  expected_pins[$];
    int unsigned errors;
    int unsigned ticks_seen;

    function new();
      foreach (frame[r, c]) frame[r][c] = '0;
      group        = 0;
      pos          = 0;
      hold_cnt     = 0;
      phase        = SCAN_SETUP;
      pixel_hold   = 32'(PIXEL_HOLD_RST);
      display_hold = 32'(DISPLAY_HOLD_RST);
      errors       = 0;
      ticks_seen   = 0;
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void set_register(logic sel, logic [APB_DATA_W-1:0] value);
      if (sel == REG_PIXEL_HOLD) pixel_hold = 32'(value[PIXEL_HOLD_W-1:0]);
      else display_hold = 32'(value[DISPLAY_HOLD_W-1:0]);
    endfunction

    // Start the hold or the clock of the pixel at the current position.
    function void enter_shift();
      hold_cnt = 0;
      phase    = (pixel_hold > 0) ? SCAN_HOLD : SCAN_CLOCK;
    endfunction

    function void advance_group();
      group    = (group + 1 >= HALF) ? 0 : group + 1;
      pos      = 0;
      hold_cnt = 0;
      phase    = SCAN_SETUP;
    endfunction

    function void note_item(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [COLOR_W-1:0] color);
      pin_state_t pins;
      if (cmd == CMD_WRITE) begin
        frame[row][col] = color;
        return;
      end
      pins = '0;
      pins.blank    = 1'b1;
      pins.row_addr = group[ROW_ADDR_W-1:0];
      if (phase == SCAN_SETUP || phase == SCAN_HOLD || phase == SCAN_CLOCK) begin
        pins.first_rgb  = frame[pos][group];
        pins.second_rgb = frame[pos][group + HALF];
      end
      case (phase)
        SCAN_SETUP: begin
          pos = 0;
          enter_shift();
        end
        SCAN_HOLD: begin
          if (hold_cnt + 1 >= pixel_hold) begin
            hold_cnt = 0;
            phase    = SCAN_CLOCK;
          end else begin
            hold_cnt++;
          end
        end
        SCAN_CLOCK: begin
          pins.shift_clk = 1'b1;
          if (pos + 1 >= ROWS) begin
            phase = SCAN_LATCH;
          end else begin
            pos++;
            enter_shift();
          end
        end
        SCAN_LATCH: begin
          pins.latch = 1'b1;
          if (display_hold > 0) begin
            hold_cnt = 0;
            phase    = SCAN_DISPLAY;
          end else begin
            advance_group();
          end
        end
        default: begin
          pins.blank = 1'b0;
          if (hold_cnt + 1 >= display_hold) advance_group();
          else hold_cnt++;
        end
      endcase
      expected_pins.push_back(pins);
    endfunction

    function string describe(pin_state_t s);
      return $sformatf("rgb1=%0d rgb2=%0d clk=%b lat=%b oe=%b row=%0d", s.first_rgb,
                       s.second_rgb, s.shift_clk, s.latch, s.blank, s.row_addr);
    endfunction

    function void check_result(pin_state_t got);
      pin_state_t want;
      if (expected_pins.size() == 0) begin
        flag($sformatf("pin state with no tick pending: %s", describe(got)));
        return;
      end
      want = expected_pins.pop_front();
      if (got.first_rgb !== want.first_rgb || got.second_rgb !== want.second_rgb ||
          got.shift_clk !== want.shift_clk || got.latch !== want.latch ||
          got.blank !== want.blank || got.row_addr !== want.row_addr)
        flag($sformatf("tick %0d expected %s, got %s", ticks_seen, describe(want),
                       describe(got)));
      ticks_seen++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  command_i     = CMD_WRITE;
  logic [ROW_W-1:0]      pixel_row_i   = '0;
  logic [COL_W-1:0]      pixel_col_i   = '0;
  logic [COLOR_W-1:0]    pixel_color_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  red_first_o, green_first_o, blue_first_o;
  logic                  red_second_o, green_second_o, blue_second_o;
  logic                  shift_clock_o, latch_strobe_o, output_enable_o;
  logic [ROW_ADDR_W-1:0] row_address_o;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pin_scoreboard sb = new();
  pin_state_t    seen_pins;
  bit            idling_on    = 1'b1;
  bit            hold_off_req = 1'b0;

  assign seen_pins = {blue_first_o, green_first_o, red_first_o, blue_second_o,
                      green_second_o, red_second_o, shift_clock_o, latch_strobe_o,
                      output_enable_o, row_address_o};

  rgb_led_matrix_scan_driver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .pixel_color_i  (pixel_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_first_o    (red_first_o),
    .green_first_o  (green_first_o),
    .blue_first_o   (blue_first_o),
    .red_second_o   (red_second_o),
    .green_second_o (green_second_o),
    .blue_second_o  (blue_second_o),
    .shift_clock_o  (shift_clock_o),
    .latch_strobe_o (latch_strobe_o),
    .output_enable_o(output_enable_o),
    .row_address_o  (row_address_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: check every accepted pin state and stall in random bursts.
  initial begin : pin_receiver
    int unsigned burst;
    int unsigned hold_left;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(seen_pins);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one item and wait until the block takes it.
  task automatic send_item(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [COLOR_W-1:0] color);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pixel_row_i   <= row;
    pixel_col_i   <= col;
    pixel_color_i <= color;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(cmd, row, col, color);
  endtask

  task automatic reg_read(logic sel, output logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a hold register with junk in the unused bits, then read it back.
  task automatic reg_write(logic sel, int unsigned field);
    logic [APB_DATA_W-1:0] value;
    logic [APB_DATA_W-1:0] kept;
    logic [APB_DATA_W-1:0] readback;
    if (sel == REG_PIXEL_HOLD) begin
      value = ($urandom() << PIXEL_HOLD_W) | field;
      kept  = value & ((1 << PIXEL_HOLD_W) - 1);
    end else begin
      value = ($urandom() << DISPLAY_HOLD_W) | field;
      kept  = value & ((1 << DISPLAY_HOLD_W) - 1);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(sel, value);
    @(posedge clk_i);
    reg_read(sel, readback);
    if (readback !== kept)
      sb.flag($sformatf("register %0d reads %0d, written %0d", sel, readback, kept));
  endtask

  task automatic set_holds(int unsigned pixel_ticks, int unsigned display_ticks);
    reg_write(REG_PIXEL_HOLD, pixel_ticks);
    reg_write(REG_DISPLAY_HOLD, display_ticks);
  endtask

  // Let every pending pin state come out, plus a margin for the output stage.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly ticks; writes favor the two columns that the current group shows.
  task automatic run_random(int unsigned count, int unsigned tick_pct, bit pressure);
    logic [COL_W-1:0] col;
    for (int unsigned i = 0; i < count; i++) begin
      if (pressure && i == count / 3) hold_off_req = 1'b1;
      col = COL_W'($urandom_range(0, COLS - 1));
      if ($urandom_range(0, 1)) col = COL_W'(sb.group + ($urandom_range(0, 1) ? HALF : 0));
      send_item(($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_WRITE,
                ROW_W'($urandom_range(0, ROWS - 1)), col,
                COLOR_W'($urandom_range(0, 7)));
    end
  endtask

  // Stimulus: reset, directed items, then random phases over several hold settings.
  initial begin : stimulus
    logic [APB_DATA_W-1:0] readback;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_read(REG_PIXEL_HOLD, readback);
    if (readback !== APB_DATA_W'(PIXEL_HOLD_RST))
      sb.flag($sformatf("pixel hold resets to %0d", readback));
    reg_read(REG_DISPLAY_HOLD, readback);
    if (readback !== APB_DATA_W'(DISPLAY_HOLD_RST))
      sb.flag($sformatf("display hold resets to %0d", readback));

    // Zero holds on both sides; corner pixels of group 0 and all colors.
    set_holds(0, 0);
    send_item(CMD_WRITE, 0, 0, 7);
    send_item(CMD_WRITE, 0, COL_W'(HALF), 2);
    send_item(CMD_WRITE, ROW_W'(ROWS - 1), 0, 1);
    send_item(CMD_WRITE, ROW_W'(ROWS - 1), COL_W'(HALF), 4);
    send_item(CMD_WRITE, 1, 0, 3);
    send_item(CMD_WRITE, 1, COL_W'(HALF), 5);
    send_item(CMD_WRITE, ROW_W'(ROWS - 1), COL_W'(COLS - 1), 6);
    send_item(CMD_WRITE, 0, COL_W'(HALF - 1), 7);
    send_item(CMD_WRITE, 2, 0, 0);
    repeat (15)
      send_item(CMD_TICK, ROW_W'($urandom_range(0, ROWS - 1)),
                COL_W'($urandom_range(0, COLS - 1)), COLOR_W'($urandom_range(0, 7)));
    run_random(350, 85, 1'b1);

    // Longest holds; the pixel hold is then cut short mid-way.
    drain();
    set_holds(255, 1023);
    run_random(80, 90, 1'b0);
    drain();
    set_holds(1, 3);
    run_random(100, 85, 1'b0);

    // Long display hold, then cut short while the group is lit.
    drain();
    set_holds(0, 1023);
    run_random(110, 92, 1'b0);
    drain();
    set_holds(2, 2);
    run_random(60, 85, 1'b0);

    // Final stretch at full rate on both sides.
    drain();
    idling_on = 1'b0;
    set_holds($urandom_range(0, 3), $urandom_range(0, 8));
    run_random(150, 85, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rgbm_pkg.sv
rtl/core/rgbm_frame_store.sv
rtl/core/rgb_led_matrix_scan_driver.sv
test/tb_top.sv
